// ----- src/ccs_pkg.sv -----
// Package for the C comment stripper: scan modes, character codes,
// result word type and queue sizing. No dependencies.
package ccs_pkg;

  // Scan modes, one-hot.
  typedef enum logic [6:0] {
    ModeNormal = 7'b0000001,
    ModeAngle  = 7'b0000010,
    ModeQuote  = 7'b0000100,
    ModeSlash  = 7'b0001000,
    ModeLine   = 7'b0010000,
    ModeBlock  = 7'b0100000,
    ModeStar   = 7'b1000000
  } scan_mode_e;

  // Characters that steer the scanner.
  localparam logic [7:0] ChLess    = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChNewline = 8'h0A;

  // One result word between front and back.
  typedef struct packed {
    logic       lone_slash_error;
    logic [7:0] out_byte;
  } ccs_item_t;

  // Queue between scanner and output stage.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Handshake between queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } ccs_qstat_t;

endpackage

// ----- src/ccs_front.sv -----
// Scanner front end: accepts input words, tracks the scan mode and
// classifies each byte as kept, dropped or error. Depends on ccs_pkg.
module ccs_front import ccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  ccs_qstat_t qstat_i,
  output logic       push_o,
  output ccs_item_t  item_o
);

  scan_mode_e mode_q, mode_d;
  logic       emit;
  logic       accept;

  assign in_ready_o = ~qstat_i.full;
  assign accept     = in_valid_i & ~qstat_i.full;

  // Next mode and result for the current byte.
  always_comb begin
    mode_d                 = mode_q;
    emit                   = 1'b0;
    item_o.out_byte        = in_byte_i;
    item_o.lone_slash_error = 1'b0;
    unique case (mode_q)
      ModeAngle: begin
        emit = 1'b1;
        if (in_byte_i == ChGreater) mode_d = ModeNormal;
      end
      ModeQuote: begin
        emit = 1'b1;
        if (in_byte_i == ChQuote) mode_d = ModeNormal;
      end
      ModeSlash: begin
        if (in_byte_i == ChSlash) begin
          mode_d = ModeLine;
        end else if (in_byte_i == ChStar) begin
          mode_d = ModeBlock;
        end else begin
          mode_d                  = ModeNormal;
          emit                    = 1'b1;
          item_o.out_byte         = 8'h00;
          item_o.lone_slash_error = 1'b1;
        end
      end
      ModeLine: begin
        if (in_byte_i == ChNewline) mode_d = ModeNormal;
      end
      ModeBlock: begin
        if (in_byte_i == ChStar) mode_d = ModeStar;
      end
      ModeStar: begin
        // Further stars keep waiting for the closing slash.
        if (in_byte_i == ChSlash) begin
          mode_d = ModeNormal;
        end else if (in_byte_i != ChStar) begin
          mode_d = ModeBlock;
        end
      end
      default: begin
        mode_d = ModeNormal;
        emit   = 1'b1;
        if (in_byte_i == ChLess) begin
          mode_d = ModeAngle;
        end else if (in_byte_i == ChQuote) begin
          mode_d = ModeQuote;
        end else if (in_byte_i == ChSlash) begin
          mode_d = ModeSlash;
          emit   = 1'b0;
        end
      end
    endcase
  end

  assign push_o = accept & emit;

  // Mode register advances on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

// ----- src/ccs_queue.sv -----
// Short result queue between scanner and output stage, push and pop
// in the same cycle allowed. Depends on ccs_pkg.
module ccs_queue import ccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ccs_item_t  item_i,
  input  logic       pop_i,
  output ccs_item_t  item_o,
  output ccs_qstat_t qstat_o
);

  ccs_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i & ~qstat_o.full;
  assign do_pop        = pop_i & ~qstat_o.empty;
  assign item_o        = mem_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/ccs_back.sv -----
// Output stage: takes result words from the queue into a registered
// stream master. Depends on ccs_pkg.
module ccs_back import ccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ccs_item_t  item_i,
  input  ccs_qstat_t qstat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ccs_item_t  out_item_o
);

  logic      valid_q;
  ccs_item_t data_q;

  // Load whenever the register is free or being drained.
  assign pop_o       = ~qstat_i.empty & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= item_i;
    end
  end

endmodule

// ----- src/c_comment_stripper.sv -----
// C comment stripper top level: one source byte in per word, comment-free
// bytes and lone-slash errors out. Depends on ccs_pkg, ccs_front,
// ccs_queue and ccs_back.
//
// Usage: source text enters one byte per word on the s_axis channel
// (s_axis_tdata). Each byte yields zero or one word on m_axis: a kept
// byte in m_axis_tdata with m_axis_tuser low, or, for a slash followed
// by anything other than a slash or a star, one word with m_axis_tuser
// high and m_axis_tdata zero. Comment bytes produce no word.
// Throughput is one byte per cycle while the queue is not full, set by
// the scan mode register in the front end. Each word is registered in
// the queue, then in the output register. A two-entry queue separates the
// scanner from the output register, so the input keeps flowing while a
// finished word waits; when the receiver stalls, the queue fills and
// s_axis_tready drops until space frees up. Reset (rst_ni low,
// asynchronous) returns the scanner to normal text and empties the queue
// and the output register.
module c_comment_stripper import ccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser    // [0] lone_slash_error
);

  ccs_qstat_t qstat;
  ccs_item_t  push_item, head_item, out_item;
  logic       push, pop;

  ccs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .qstat_i    (qstat),
    .push_o     (push),
    .item_o     (push_item)
  );

  ccs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .qstat_o (qstat)
  );

  ccs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = out_item.out_byte;
  assign m_axis_tuser = out_item.lone_slash_error;

endmodule
